### rtl/lsc_pkg.sv
// ----------------------------------------------------------------------------
// lsc_pkg: shared types and helpers for the life stencil core
// Sizes, register indexes, window column type and the B3/S23 rule.
// ----------------------------------------------------------------------------
package lsc_pkg;

  localparam int MAX_WIDTH     = 1024;
  localparam int MAX_HEIGHT    = 1024;
  localparam int MATERIAL_BITS = 4;
  localparam int COL_BITS      = $clog2(MAX_WIDTH);
  localparam int ROW_BITS      = $clog2(MAX_HEIGHT);
  localparam int SIZE_BITS     = 11;
  localparam int CFG_BITS      = 11;
  localparam int COUNT_BITS    = 4;

  localparam logic [MATERIAL_BITS-1:0] EMPTY_RESET = MATERIAL_BITS'(0);
  localparam logic [MATERIAL_BITS-1:0] ALIVE_RESET = MATERIAL_BITS'(7);

  typedef logic [MATERIAL_BITS-1:0] material_t;
  typedef logic [COL_BITS-1:0]      col_t;
  typedef logic [ROW_BITS-1:0]      row_t;

  typedef enum logic [1:0] {
    REG_GRID_WIDTH  = 2'd0,
    REG_GRID_HEIGHT = 2'd1,
    REG_EMPTY_CODE  = 2'd2,
    REG_ALIVE_CODE  = 2'd3
  } reg_index_t;

  // One window column: two rows above and the current row.
  typedef struct packed {
    material_t top;
    material_t mid;
    material_t bot;
  } column_t;

  // Last column index for a programmed width, saturated to 3..MAX_WIDTH.
  function automatic col_t last_col_of(input logic [SIZE_BITS-1:0] value);
    col_t res;
    if (int'(value) < 3) begin
      res = col_t'(2);
    end else if (int'(value) > MAX_WIDTH) begin
      res = col_t'(MAX_WIDTH - 1);
    end else begin
      res = col_t'(int'(value) - 1);
    end
    return res;
  endfunction

  // Last row index for a programmed height, saturated to 3..MAX_HEIGHT.
  function automatic row_t last_row_of(input logic [SIZE_BITS-1:0] value);
    row_t res;
    if (int'(value) < 3) begin
      res = row_t'(2);
    end else if (int'(value) > MAX_HEIGHT) begin
      res = row_t'(MAX_HEIGHT - 1);
    end else begin
      res = row_t'(int'(value) - 1);
    end
    return res;
  endfunction

  // B3/S23: alive survives on 2 or 3, empty is born on 3, others hold.
  function automatic material_t life_rule(input material_t       centre,
                                          input logic [COUNT_BITS-1:0] n,
                                          input material_t       empty_code,
                                          input material_t       alive_code);
    material_t res;
    res = centre;
    if (centre == alive_code) begin
      if (n != COUNT_BITS'(2) && n != COUNT_BITS'(3)) begin
        res = empty_code;
      end
    end else if (centre == empty_code && n == COUNT_BITS'(3)) begin
      res = alive_code;
    end
    return res;
  endfunction

endpackage

### rtl/lsc_ram.sv
// ----------------------------------------------------------------------------
// lsc_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lsc_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/lsc_window_cell.sv
// ----------------------------------------------------------------------------
// lsc_window_cell: one column of the 3x3 window
// Holds three material codes and hands them to the next cell on each shift.
// ----------------------------------------------------------------------------
module lsc_window_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             shift,
  input  lsc_pkg::column_t col_in,
  output lsc_pkg::column_t col_out
);
  import lsc_pkg::*;

  column_t held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (shift) begin
      held <= col_in;
    end
  end

  assign col_out = held;

endmodule

### rtl/life_automaton_stencil_core.sv
// ----------------------------------------------------------------------------
// life_automaton_stencil_core: B3/S23 stencil over a raster cell stream
// Two line stores and a chain of window cells form a 3x3 neighborhood; each
// interior cell is reported with its next-generation code and a changed flag.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------------
//  in       | in_valid / in_stall       | cell_material, frame_start
//  out      | out_valid / out_stall     | cell_x, cell_y, new_material, changed
//  cfg      | cfg_wr_en                 | cfg_index, cfg_data
//
//  One cell per clock while out_stall does not hold the flow. A beat passes
//  through stage 1 (line store read), then the output register (rule, count).
//  Reset (rst, synchronous) clears counters, window cells and valid flags;
//  the line stores are not cleared.
//  out_stall holds the output register; a stage-1 beat with a result then
//  waits and in_stall rises. Beats with no result drain regardless.
// ----------------------------------------------------------------------------
module life_automaton_stencil_core (
  input  logic                               clk,
  input  logic                               rst,
  // configuration
  input  logic                               cfg_wr_en,
  input  lsc_pkg::reg_index_t                cfg_index,
  input  logic [lsc_pkg::CFG_BITS-1:0]       cfg_data,
  // input stream
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [lsc_pkg::MATERIAL_BITS-1:0]  cell_material,
  input  logic                               frame_start,
  // output stream
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [lsc_pkg::COL_BITS-1:0]       cell_x,
  output logic [lsc_pkg::ROW_BITS-1:0]       cell_y,
  output logic [lsc_pkg::MATERIAL_BITS-1:0]  new_material,
  output logic                               changed
);
  import lsc_pkg::*;

  // Configuration, kept as saturated last indexes.
  col_t      last_col;
  row_t      last_row;
  material_t empty_code;
  material_t alive_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_col   <= col_t'(MAX_WIDTH - 1);
      last_row   <= row_t'(MAX_HEIGHT - 1);
      empty_code <= EMPTY_RESET;
      alive_code <= ALIVE_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_GRID_WIDTH:  last_col   <= last_col_of(cfg_data[SIZE_BITS-1:0]);
        REG_GRID_HEIGHT: last_row   <= last_row_of(cfg_data[SIZE_BITS-1:0]);
        REG_EMPTY_CODE:  empty_code <= cfg_data[MATERIAL_BITS-1:0];
        REG_ALIVE_CODE:  alive_code <= cfg_data[MATERIAL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Stage 1 registers.
  logic      s1_valid;
  material_t s1_cur;
  col_t      s1_col;
  row_t      s1_row;
  logic      s1_fwd;
  material_t s1_fwd_two;
  material_t s1_fwd_one;

  logic      s1_adv;
  logic      s1_has_result;
  logic      in_accept;

  // Raster counters and the position of the arriving beat.
  col_t column_count;
  row_t row_count;
  col_t in_col;
  row_t in_row;

  assign in_col    = frame_start ? '0 : column_count;
  assign in_row    = frame_start ? '0 : row_count;
  assign in_stall  = s1_valid && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_accept) begin
      if (in_col >= last_col) begin
        column_count <= '0;
        row_count    <= (in_row >= last_row) ? '0 : in_row + row_t'(1);
      end else begin
        column_count <= in_col + col_t'(1);
        row_count    <= in_row;
      end
    end
  end

  // Line stores: read at accept, write back when stage 1 advances.
  material_t rd_two;
  material_t rd_one;
  material_t fresh_two;
  material_t fresh_one;

  lsc_ram #(.WIDTH(MATERIAL_BITS), .DEPTH(MAX_WIDTH)) u_row_two_above (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_col),
    .wr_data (fresh_one),
    .rd_en   (in_accept),
    .rd_addr (in_col),
    .rd_data (rd_two)
  );

  lsc_ram #(.WIDTH(MATERIAL_BITS), .DEPTH(MAX_WIDTH)) u_row_above (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_col),
    .wr_data (s1_cur),
    .rd_en   (in_accept),
    .rd_addr (in_col),
    .rd_data (rd_one)
  );

  // Forward the write-back when the next beat reads the column being written.
  assign fresh_two = s1_fwd ? s1_fwd_two : rd_two;
  assign fresh_one = s1_fwd ? s1_fwd_one : rd_one;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cur     <= cell_material;
      s1_col     <= in_col;
      s1_row     <= in_row;
      s1_fwd     <= s1_adv && (s1_col == in_col);
      s1_fwd_two <= fresh_one;
      s1_fwd_one <= s1_cur;
    end
  end

  // Window: chain of two cells, newest column first.
  column_t fresh_col;
  column_t near_col;
  column_t far_col;

  assign fresh_col = '{top: fresh_two, mid: fresh_one, bot: s1_cur};

  lsc_window_cell u_cell_near (
    .clk     (clk),
    .rst     (rst),
    .shift   (s1_adv),
    .col_in  (fresh_col),
    .col_out (near_col)
  );

  lsc_window_cell u_cell_far (
    .clk     (clk),
    .rst     (rst),
    .shift   (s1_adv),
    .col_in  (near_col),
    .col_out (far_col)
  );

  // Count live neighbors around the centre (middle of the near column).
  logic [COUNT_BITS-1:0] n_alive;
  material_t             next_code;
  material_t             nbr [8];

  assign nbr[0] = far_col.top;
  assign nbr[1] = far_col.mid;
  assign nbr[2] = far_col.bot;
  assign nbr[3] = near_col.top;
  assign nbr[4] = near_col.bot;
  assign nbr[5] = fresh_col.top;
  assign nbr[6] = fresh_col.mid;
  assign nbr[7] = fresh_col.bot;

  always_comb begin
    n_alive = '0;
    for (int i = 0; i < 8; i++) begin
      n_alive = n_alive + COUNT_BITS'(nbr[i] == alive_code);
    end
  end

  assign next_code     = life_rule(near_col.mid, n_alive, empty_code, alive_code);
  assign s1_has_result = (s1_col >= col_t'(2)) && (s1_row >= row_t'(2));
  // Advance unless a result must wait on a stalled output register.
  assign s1_adv = s1_valid && (!s1_has_result || !out_valid || !out_stall);

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_has_result) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_has_result) begin
      cell_x       <= s1_col - col_t'(1);
      cell_y       <= s1_row - row_t'(1);
      new_material <= next_code;
      changed      <= (next_code != near_col.mid);
    end
  end

endmodule

### sim/life_automaton_stencil_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_automaton_stencil_core_tb: self-checking bench for the B3/S23 stencil
// Streams raster frames of material codes through the core, predicts every
// interior cell of the next generation in a local model, and compares each
// result beat field by field. Covers directed corner frames, saturated and
// lowered grid sizes, equal empty/alive codes, back-pressure and random frames.
// ----------------------------------------------------------------------------
module life_automaton_stencil_core_tb;
  import lsc_pkg::*;

  localparam int HALF_PERIOD    = 10;
  localparam int RESET_CYCLES   = 5;
  localparam int GAP_PERCENT    = 13;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 60;
  localparam int MAX_REPORTS    = 20;

  // Shorthands for the reset codes and a third material, used by the directed frames.
  localparam material_t LIVE = ALIVE_RESET;
  localparam material_t VOID = EMPTY_RESET;
  localparam material_t ROCK = material_t'(15);

  typedef struct packed {
    col_t      x;
    row_t      y;
    material_t material;
    logic      changed;
  } cell_result_t;

  typedef struct {
    material_t    material;
    logic         mark;
    bit           typed;
    cell_result_t want;
  } stim_row_t;

  // DUT ports; the inputs are driven to known values from time zero.
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  reg_index_t           cfg_index = REG_GRID_WIDTH;
  logic [CFG_BITS-1:0]  cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  material_t            cell_material = '0;
  logic                 frame_start = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  col_t                 cell_x;
  row_t                 cell_y;
  material_t            new_material;
  logic                 changed;

  // Bench control.
  bit                   sender_gaps_on = 1'b0;
  bit                   recv_gaps_on = 1'b0;
  int                   holds_asked = 0;
  int                   mismatches = 0;
  int                   quiet_cycles = 0;
  cell_result_t         next_gen_queue[$];
  stim_row_t            corner_table[$];

  // Local copy of the core: registers, line stores, window and raster position.
  logic [CFG_BITS-1:0]  gen_width = CFG_BITS'(MAX_WIDTH);
  logic [CFG_BITS-1:0]  gen_height = CFG_BITS'(MAX_HEIGHT);
  material_t            gen_empty = EMPTY_RESET;
  material_t            gen_alive = ALIVE_RESET;
  material_t            store_above [MAX_WIDTH];
  material_t            store_two_above [MAX_WIDTH];
  material_t            win_old [3];
  material_t            win_mid [3];
  int                   col_pos = 0;
  int                   row_pos = 0;

  life_automaton_stencil_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .cell_material (cell_material),
    .frame_start   (frame_start),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .cell_x        (cell_x),
    .cell_y        (cell_y),
    .new_material  (new_material),
    .changed       (changed)
  );

  always #HALF_PERIOD clk = ~clk;

  // --------------------------------------------------------------------------
  // Next-generation predictor. Advance the raster position by one cell and,
  // once the window covers a full 3x3 interior neighborhood, return the
  // finished cell one column left and one row up.
  // --------------------------------------------------------------------------
  function automatic bit evolve_cell(input material_t cur, input logic mark,
                                     output cell_result_t res);
    int        w;
    int        h;
    int        c;
    int        r;
    int        n;
    material_t fresh [3];
    material_t centre;
    material_t nxt;
    bit        has_result;
    // Saturate the programmed sizes to the supported range.
    w = (gen_width < 3) ? 3 : (gen_width > MAX_WIDTH) ? MAX_WIDTH : int'(gen_width);
    h = (gen_height < 3) ? 3 : (gen_height > MAX_HEIGHT) ? MAX_HEIGHT : int'(gen_height);
    // A frame mark restarts the raster wherever the counters stood.
    if (mark) begin
      col_pos = 0;
      row_pos = 0;
    end
    c = (col_pos >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_pos;
    r = row_pos;
    fresh[0] = store_two_above[c];
    fresh[1] = store_above[c];
    fresh[2] = cur;
    has_result = (c >= 2) && (r >= 2);
    res = '0;
    if (has_result) begin
      centre = win_mid[1];
      n = int'(win_mid[0] == gen_alive) + int'(win_mid[2] == gen_alive);
      for (int k = 0; k < 3; k++) begin
        n += int'(win_old[k] == gen_alive) + int'(fresh[k] == gen_alive);
      end
      // Alive is tested first, so equal codes follow the survival rule.
      nxt = centre;
      if (centre == gen_alive) begin
        if (n != 2 && n != 3) nxt = gen_empty;
      end else if (centre == gen_empty && n == 3) begin
        nxt = gen_alive;
      end
      res.x        = col_t'(c - 1);
      res.y        = row_t'(r - 1);
      res.material = nxt;
      res.changed  = (nxt != centre);
    end
    win_old = win_mid;
    win_mid = fresh;
    store_two_above[c] = fresh[1];
    store_above[c]     = cur;
    // A counter at or past the last column (row) wraps on this advance.
    if (c >= w - 1) begin
      col_pos = 0;
      row_pos = (r >= h - 1) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
    return has_result;
  endfunction

  // Mostly alive and empty codes so the rule fires often; some other material.
  function automatic material_t pick_material();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 45) return gen_alive;
    if (roll < 85) return gen_empty;
    return material_t'($urandom_range(15));
  endfunction

  function automatic void add_row(input material_t m, input logic mark,
                                  input bit typed = 1'b0, input int x = 0,
                                  input int y = 0, input material_t nm = '0,
                                  input logic chg = 1'b0);
    stim_row_t row;
    row.material     = m;
    row.mark         = mark;
    row.typed        = typed;
    row.want.x       = col_t'(x);
    row.want.y       = row_t'(y);
    row.want.material = nm;
    row.want.changed = chg;
    corner_table = {corner_table, row};
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // Input side. Idle at random when enabled, then hold the beat until the core
  // takes it; predict at the accepting edge. A typed row overrides the model.
  // --------------------------------------------------------------------------
  task automatic send_cell(input material_t m, input logic mark, input bit typed,
                           input cell_result_t typed_res);
    cell_result_t res;
    while (sender_gaps_on && $urandom_range(99) < GAP_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    cell_material <= m;
    frame_start   <= mark;
    do @(posedge clk); while (in_stall);
    if (evolve_cell(m, mark, res) && !typed) next_gen_queue = {next_gen_queue, res};
    if (typed) next_gen_queue = {next_gen_queue, typed_res};
  endtask

  task automatic send_frame(input bit mark_first, input int cells);
    for (int k = 0; k < cells; k++) begin
      send_cell(pick_material(), mark_first && (k == 0), 1'b0, '0);
    end
  endtask

  // Drop valid, wait for every expected beat, then let the pipeline empty out
  // since the last cells of a frame carry no result.
  task automatic settle();
    in_valid <= 1'b0;
    while (next_gen_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write enable stays high across back-to-back writes; the caller lowers it.
  task automatic write_reg(input reg_index_t idx, input logic [CFG_BITS-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      REG_GRID_WIDTH:  gen_width  = value;
      REG_GRID_HEIGHT: gen_height = value;
      REG_EMPTY_CODE:  gen_empty  = material_t'(value);
      REG_ALIVE_CODE:  gen_alive  = material_t'(value);
      default: ;
    endcase
  endtask

  task automatic configure(input logic [CFG_BITS-1:0] w, input logic [CFG_BITS-1:0] h,
                           input material_t e, input material_t a);
    write_reg(REG_GRID_WIDTH, w);
    write_reg(REG_GRID_HEIGHT, h);
    write_reg(REG_EMPTY_CODE, CFG_BITS'(e));
    write_reg(REG_ALIVE_CODE, CFG_BITS'(a));
    cfg_wr_en <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Output side. Honor a requested long hold first, counted here; otherwise
  // stall at random when enabled. At most one assignment to out_stall per edge.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int served;
    served = 0;
    forever begin
      @(posedge clk);
      if (served != holds_asked) begin
        served++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_stall <= recv_gaps_on && ($urandom_range(99) < GAP_PERCENT);
      end
    end
  end

  // Compare each accepted result beat with the oldest prediction.
  always @(posedge clk) begin : check_results
    cell_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (next_gen_queue.size() == 0) begin
        report_mismatch($sformatf("unexpected beat at (%0d,%0d)", cell_x, cell_y));
      end else begin
        want = next_gen_queue.pop_front();
        if (cell_x !== want.x)
          report_mismatch($sformatf("cell_x %0d, want %0d", cell_x, want.x));
        if (cell_y !== want.y)
          report_mismatch($sformatf("cell_y %0d, want %0d", cell_y, want.y));
        if (new_material !== want.material)
          report_mismatch($sformatf("new_material %0d at (%0d,%0d), want %0d",
                                    new_material, want.x, want.y, want.material));
        if (changed !== want.changed)
          report_mismatch($sformatf("changed %b at (%0d,%0d), want %b",
                                    changed, want.x, want.y, want.changed));
      end
    end
  end

  // End the run when neither channel has moved a beat for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus sequence.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int                  random_items;
    int                  frames;
    int                  area;
    int                  cells;
    int                  ew;
    int                  eh;
    bit                  at_origin;
    logic [CFG_BITS-1:0] rw;
    logic [CFG_BITS-1:0] rh;
    material_t           re;
    material_t           ra;

    // Model line stores start unknown in the core; zero them here. They are
    // never consulted before the current frame has written them.
    foreach (store_above[i]) begin
      store_above[i]     = '0;
      store_two_above[i] = '0;
    end
    foreach (win_old[i]) begin
      win_old[i] = '0;
      win_mid[i] = '0;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Corner frames at 4x3 with the reset codes. Two stray cells lead in so the
    // frame mark must pull the raster back to the origin. The first frame
    // shows survival on two, birth on three and both code extremes; the second
    // arrives without a mark after the wrap and shows death and an inert cell.
    write_reg(REG_GRID_WIDTH, CFG_BITS'(4));
    write_reg(REG_GRID_HEIGHT, CFG_BITS'(3));
    cfg_wr_en <= 1'b0;
    add_row(material_t'(5), 1'b0); add_row(ROCK, 1'b0);
    add_row(LIVE, 1'b1); add_row(LIVE, 1'b0); add_row(VOID, 1'b0); add_row(LIVE, 1'b0);
    add_row(VOID, 1'b0); add_row(LIVE, 1'b0); add_row(VOID, 1'b0); add_row(VOID, 1'b0);
    add_row(VOID, 1'b0); add_row(VOID, 1'b0);
    add_row(VOID, 1'b0, 1'b1, 1, 1, LIVE, 1'b0);
    add_row(ROCK, 1'b0, 1'b1, 2, 1, LIVE, 1'b1);
    add_row(LIVE, 1'b0); add_row(LIVE, 1'b0); add_row(LIVE, 1'b0); add_row(LIVE, 1'b0);
    add_row(LIVE, 1'b0); add_row(LIVE, 1'b0); add_row(ROCK, 1'b0); add_row(LIVE, 1'b0);
    add_row(LIVE, 1'b0); add_row(LIVE, 1'b0);
    add_row(LIVE, 1'b0, 1'b1, 1, 1, VOID, 1'b1);
    add_row(LIVE, 1'b0, 1'b1, 2, 1, ROCK, 1'b0);
    sender_gaps_on = 1'b1;
    recv_gaps_on  <= 1'b1;
    foreach (corner_table[i]) begin
      send_cell(corner_table[i].material, corner_table[i].mark, corner_table[i].typed,
                corner_table[i].want);
    end
    settle();

    // Lowered sizes: stop at column 6 of row 3 in an 8x5 grid, then shrink to
    // 5x3 without a mark so both counters sit past their new last value.
    configure(CFG_BITS'(8), CFG_BITS'(5), VOID, LIVE);
    send_frame(1'b1, 40);
    send_frame(1'b0, 30);
    settle();
    configure(CFG_BITS'(5), CFG_BITS'(3), VOID, LIVE);
    send_frame(1'b0, 1);
    send_frame(1'b0, 15);
    send_frame(1'b0, 15);
    settle();

    // Saturated sizes with swapped code extremes, run with no idling at all:
    // undersized widths and heights clamp up, an oversized height clamps down.
    sender_gaps_on = 1'b0;
    recv_gaps_on  <= 1'b0;
    configure(CFG_BITS'(0), CFG_BITS'(1), ROCK, VOID);
    send_frame(1'b1, 36);
    settle();
    configure(CFG_BITS'(1), '1, VOID, ROCK);
    send_frame(1'b1, 45);
    settle();
    sender_gaps_on = 1'b1;
    recv_gaps_on  <= 1'b1;

    // Empty and alive codes equal.
    configure(CFG_BITS'(6), CFG_BITS'(5), material_t'(9), material_t'(9));
    send_frame(1'b1, 30);
    send_frame(1'b1, 30);
    settle();

    // Back-pressure: hold the result side for a long stretch while cells keep
    // coming, so the core fills and stalls its input; then drain completely.
    configure(CFG_BITS'(6), CFG_BITS'(6), VOID, LIVE);
    holds_asked <= holds_asked + 1;
    send_frame(1'b1, 36);
    send_frame(1'b0, 36);
    settle();

    // Random phases: mostly whole frames with random content, some starting
    // without a mark after a clean wrap, some cut short and restarted.
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      rw = ($urandom_range(19) == 0) ? CFG_BITS'($urandom_range(2))
                                     : CFG_BITS'($urandom_range(3, 12));
      rh = ($urandom_range(19) == 0) ? CFG_BITS'($urandom_range(2))
                                     : CFG_BITS'($urandom_range(3, 7));
      ra = material_t'($urandom_range(15));
      re = ($urandom_range(4) == 0) ? ra : material_t'($urandom_range(15));
      configure(rw, rh, re, ra);
      ew = (rw < 3) ? 3 : int'(rw);
      eh = (rh < 3) ? 3 : int'(rh);
      area = ew * eh;
      at_origin = 1'b0;
      frames = $urandom_range(1, 3);
      repeat (frames) begin
        if ($urandom_range(9) == 0) begin
          cells = $urandom_range(1, area - 1);
          send_frame(1'b1, cells);
          at_origin = 1'b0;
        end else begin
          cells = area;
          send_frame(!at_origin || ($urandom_range(3) != 0), cells);
          at_origin = 1'b1;
        end
        random_items += cells;
      end
      settle();
    end

    in_valid <= 1'b0;
    if (mismatches == 0 && next_gen_queue.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
